/* rtl/bit_ring_fifo_unit_assert.svh */
// Assertion macros; clk and arst_n are taken from the enclosing module.
`ifndef BIT_RING_FIFO_UNIT_ASSERT_SVH
`define BIT_RING_FIFO_UNIT_ASSERT_SVH

`define BRF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bit_ring_fifo_unit: assertion failed");

`define BRF_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

/* rtl/brf_pkg.sv */
package brf_pkg;

	localparam int RING_BYTES_DEF     = 1024;
	localparam int MAX_FIELD_BITS_DEF = 32;

	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 6;
	localparam int STORED_W = 14;
	localparam int FREE_W   = 13;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_GET   = 2'd1,
		CMD_FLUSH = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

endpackage

/* rtl/brf_ifs.sv */
interface brf_req_if;
	import brf_pkg::*;

	logic                valid;
	logic                ready;
	cmd_t                cmd;
	logic [DATA_W-1:0]   data;
	logic [COUNT_W-1:0]  bit_count;

	modport source (output valid, output cmd, output data, output bit_count, input ready);
	modport sink   (input valid, input cmd, input data, input bit_count, output ready);
endinterface

interface brf_rsp_if;
	import brf_pkg::*;

	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   read_data;
	logic [STORED_W-1:0] bits_stored;
	logic [FREE_W-1:0]   bits_free;

	modport source (output valid, output read_data, output bits_stored, output bits_free,
		input ready);
	modport sink   (input valid, input read_data, input bits_stored, input bits_free,
		output ready);
endinterface

/* rtl/brf_level.sv */
module brf_level #(
	parameter int RING_BYTES = brf_pkg::RING_BYTES_DEF
) (
	input  logic [$clog2(RING_BYTES)-1:0] write_index,
	input  logic [$clog2(RING_BYTES)-1:0] read_index,
	input  logic [3:0]                    read_cache_bits,
	output logic [brf_pkg::STORED_W-1:0]  bits_stored,
	output logic [brf_pkg::FREE_W-1:0]    bits_free
);
	import brf_pkg::*;

	localparam int IW = $clog2(RING_BYTES);
	localparam int SW = IW + 4;
	localparam logic [SW-1:0] CAP = SW'((RING_BYTES - 1) * 8);

	logic [IW:0]   diff_raw;
	logic [IW-1:0] diff;
	logic [SW-1:0] stored_full;
	logic [SW-1:0] free_full;

	always_comb begin
		diff_raw = {1'b0, write_index} - {1'b0, read_index};
		if (write_index < read_index) begin
			diff_raw = diff_raw + (IW+1)'(RING_BYTES);
		end
		diff        = diff_raw[IW-1:0];
		stored_full = {1'b0, diff, 3'b000} + {{(SW-4){1'b0}}, read_cache_bits};
		free_full   = (CAP > stored_full) ? CAP - stored_full : '0;
	end

	assign bits_stored = STORED_W'(stored_full);
	assign bits_free   = FREE_W'(free_full);

endmodule

/* rtl/bit_ring_fifo_unit.sv */
// Sequence, accept to result: flush, clear and zero-count commands go straight to S_DONE;
// put: S_PUT handles one byte chunk per step, then S_DONE;
// get: S_GET takes a chunk from the read cache, or reads a ring byte that S_WAIT then uses.
// One item in flight; the next item is taken once the result has loaded into the output register.
// The byte-wide ring RAM (one access per cycle) sets the rate.
// arst_n clears pointers and caches; ring contents are not cleared.
module bit_ring_fifo_unit #(
	parameter int RING_BYTES     = brf_pkg::RING_BYTES_DEF,
	parameter int MAX_FIELD_BITS = brf_pkg::MAX_FIELD_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	brf_req_if.sink    req,
	brf_rsp_if.source  rsp
);
	import brf_pkg::*;

	localparam int IW = $clog2(RING_BYTES);
	localparam logic [IW-1:0]      LAST_IDX = IW'(RING_BYTES - 1);
	localparam logic [COUNT_W-1:0] MAX_CNT  = COUNT_W'(MAX_FIELD_BITS);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PUT  = 5'b00010,
		S_GET  = 5'b00100,
		S_WAIT = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [7:0] low_mask(input logic [3:0] k);
		logic [8:0] m;
		m = (9'd1 << k) - 9'd1;
		return m[7:0];
	endfunction

	state_t              state_q;
	logic [IW-1:0]       widx_q;
	logic [IW-1:0]       ridx_q;
	logic [7:0]          wc_q;
	logic [2:0]          wcb_q;
	logic [7:0]          rc_q;
	logic [3:0]          rcb_q;
	logic [DATA_W-1:0]   data_q;
	logic [COUNT_W-1:0]  rem_q;
	logic [DATA_W-1:0]   got_q;
	logic                rsp_valid_q;
	logic [DATA_W-1:0]   rsp_data_q;
	logic [STORED_W-1:0] rsp_stored_q;
	logic [FREE_W-1:0]   rsp_free_q;

	logic [7:0] ring_mem [RING_BYTES];
	logic [7:0] rd_data_q;

	logic                accept;
	logic [COUNT_W-1:0]  cnt_sat;
	logic [3:0]          room;
	logic [3:0]          k_put;
	logic [COUNT_W-1:0]  put_shift;
	logic [DATA_W-1:0]   put_shifted;
	logic [7:0]          chunk;
	logic [7:0]          wc_new;
	logic [3:0]          wcb_sum;
	logic [7:0]          get_src;
	logic [3:0]          avail;
	logic [3:0]          k_get;
	logic [7:0]          get_bits;
	logic [DATA_W-1:0]   got_new;
	logic                mem_we;
	logic [IW-1:0]       mem_wa;
	logic [7:0]          mem_wd;
	logic                mem_re;
	logic                rsp_load;
	logic [STORED_W-1:0] lvl_stored;
	logic [FREE_W-1:0]   lvl_free;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign cnt_sat   = (req.bit_count > MAX_CNT) ? MAX_CNT : req.bit_count;

	always_comb begin
		room        = 4'd8 - {1'b0, wcb_q};
		k_put       = (rem_q < {2'b00, room}) ? rem_q[3:0] : room;
		put_shift   = rem_q - {2'b00, k_put};
		put_shifted = data_q >> put_shift;
		chunk       = put_shifted[7:0] & low_mask(k_put);
		wc_new      = wc_q | (chunk << (room - k_put));
		wcb_sum     = {1'b0, wcb_q} + k_put;

		get_src  = (state_q == S_WAIT) ? rd_data_q : rc_q;
		avail    = (state_q == S_WAIT) ? 4'd8 : rcb_q;
		k_get    = (rem_q < {2'b00, avail}) ? rem_q[3:0] : avail;
		get_bits = (get_src >> (avail - k_get)) & low_mask(k_get);
		got_new  = (got_q << k_get) | {{(DATA_W-8){1'b0}}, get_bits};
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = widx_q;
		mem_wd = wc_new;
		if (accept && req.cmd == CMD_FLUSH && wcb_q != 3'd0) begin
			mem_we = 1'b1;
			mem_wd = wc_q;
		end else if (state_q == S_PUT && wcb_sum[3]) begin
			mem_we = 1'b1;
		end
		mem_re = (state_q == S_GET) && (rcb_q == 4'd0);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= ring_mem[ridx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			widx_q  <= '0;
			ridx_q  <= '0;
			wc_q    <= '0;
			wcb_q   <= '0;
			rc_q    <= '0;
			rcb_q   <= '0;
			data_q  <= '0;
			rem_q   <= '0;
			got_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						got_q <= '0;
						rem_q <= cnt_sat;
						data_q <= req.data;
						unique case (req.cmd)
							CMD_PUT: begin
								state_q <= (cnt_sat == '0) ? S_DONE : S_PUT;
							end
							CMD_GET: begin
								state_q <= (cnt_sat == '0) ? S_DONE : S_GET;
							end
							CMD_FLUSH: begin
								if (wcb_q != 3'd0) begin
									widx_q <= inc_idx(widx_q);
									wc_q   <= '0;
									wcb_q  <= '0;
								end
								state_q <= S_DONE;
							end
							CMD_CLEAR: begin
								widx_q  <= '0;
								ridx_q  <= '0;
								wc_q    <= '0;
								wcb_q   <= '0;
								rc_q    <= '0;
								rcb_q   <= '0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_PUT: begin
					rem_q <= rem_q - {2'b00, k_put};
					if (wcb_sum[3]) begin
						widx_q <= inc_idx(widx_q);
						wc_q   <= '0;
						wcb_q  <= '0;
					end else begin
						wc_q   <= wc_new;
						wcb_q  <= wcb_sum[2:0];
					end
					if (rem_q == {2'b00, k_put}) begin
						state_q <= S_DONE;
					end
				end
				S_GET: begin
					if (rcb_q == 4'd0) begin
						state_q <= S_WAIT;
					end else begin
						rcb_q <= rcb_q - k_get;
						got_q <= got_new;
						rem_q <= rem_q - {2'b00, k_get};
						if (rem_q == {2'b00, k_get}) begin
							state_q <= S_DONE;
						end
					end
				end
				S_WAIT: begin
					rc_q   <= rd_data_q;
					rcb_q  <= 4'd8 - k_get;
					ridx_q <= inc_idx(ridx_q);
					got_q  <= got_new;
					rem_q  <= rem_q - {2'b00, k_get};
					state_q <= (rem_q == {2'b00, k_get}) ? S_DONE : S_GET;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	brf_level #(
		.RING_BYTES(RING_BYTES)
	) u_brf_level (
		.write_index    (widx_q),
		.read_index     (ridx_q),
		.read_cache_bits(rcb_q),
		.bits_stored    (lvl_stored),
		.bits_free      (lvl_free)
	);

	// output register: result waits here while the next item is taken
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_data_q   <= got_q;
			rsp_stored_q <= lvl_stored;
			rsp_free_q   <= lvl_free;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_data   = rsp_data_q;
	assign rsp.bits_stored = rsp_stored_q;
	assign rsp.bits_free   = rsp_free_q;

endmodule

/* rtl/brf_checker.sv */
`include "bit_ring_fifo_unit_assert.svh"

module brf_checker #(
	parameter int RING_BYTES = brf_pkg::RING_BYTES_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [brf_pkg::DATA_W-1:0]    rsp_read_data,
	input logic [brf_pkg::STORED_W-1:0]  bits_stored,
	input logic [brf_pkg::FREE_W-1:0]    bits_free
);
	import brf_pkg::*;

	localparam int CAP   = (RING_BYTES - 1) * 8;
	localparam bit EXACT = (RING_BYTES * 8) < (1 << STORED_W);

	logic [1:0] outstanding_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 2'((req_valid && req_ready) ? 1 : 0)
				- 2'((rsp_valid && rsp_ready) ? 1 : 0);
		end
	end

	`BRF_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) && $stable(bits_stored) && $stable(bits_free))
	`BRF_ASSERT(a_one_item, req_valid && req_ready |=> !req_ready)
	`BRF_ASSERT_MSG(a_no_extra_rsp, rsp_valid |-> outstanding_q != 2'd0, "result without an item")
	`BRF_ASSERT(a_bounded, outstanding_q != 2'd3)
	`BRF_ASSERT_MSG(a_level_sum, rsp_valid && EXACT && (int'(bits_stored) <= CAP) |-> int'(bits_free) == ((CAP - int'(bits_stored)) & ((1 << FREE_W) - 1)), "free and stored disagree")

endmodule

bind bit_ring_fifo_unit brf_checker #(
	.RING_BYTES(RING_BYTES)
) u_brf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_read_data(rsp.read_data),
	.bits_stored  (rsp.bits_stored),
	.bits_free    (rsp.bits_free)
);
